/* hdl/swbt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swbt_pkg
// Shared types and constants of the single-wire byte transceiver.
// ----------------------------------------------------------------------------
package swbt_pkg;

   localparam int unsigned QUEUE_DEPTH_DEF = 2;
   localparam int unsigned CSR_ADDR_W      = 3;
   localparam int unsigned CSR_DATA_W      = 32;

   localparam logic [7:0]  CMD_NUMBER          = 8'h43;  // 'C'
   localparam logic [15:0] BIT_PERIOD_RST      = 16'd16;
   localparam logic [14:0] HALF_BIT_PERIOD_RST = 15'd8;
   localparam logic [2:0]  NUMBER_BYTES        = 3'd4;
   localparam logic [2:0]  LAST_BIT            = 3'd7;

   typedef enum logic [1:0] {
      ACT_TICK   = 2'd0,
      ACT_SEND   = 2'd1,
      ACT_RECV   = 2'd2,
      ACT_NUMBER = 2'd3
   } action_type;

   typedef enum logic [0:0] {
      REG_BIT_PERIOD      = 1'b0,
      REG_HALF_BIT_PERIOD = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      DRV_RELEASED = 2'd0,
      DRV_WEAK     = 2'd1,
      DRV_STRONG   = 2'd2
   } drive_type;

   // classified item, front to back
   typedef struct packed {
      logic        start_tx;
      logic        start_rx;
      logic        load_num;
      logic [7:0]  first_byte;
      logic [31:0] number;
      logic        line;
   } work_type;

   typedef struct packed {
      logic [1:0] drive_mode;
      logic       drive_level;
      logic [7:0] rx_data;
      logic       rx_valid;
      logic       tx_done;
      logic       busy;
   } result_type;

endpackage
`default_nettype wire

/* hdl/swbt_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swbt_front
// Accepts request items and decodes the action into a work record.
// ----------------------------------------------------------------------------
module swbt_front import swbt_pkg::*; (
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_tx_byte,
   input  logic [31:0] req_number,
   input  logic        req_line_in,
   output logic        q_push,
   output work_type    q_work,
   input  logic        q_ready
);

   always_comb begin
      q_work            = '0;
      q_work.number     = req_number;
      q_work.line       = req_line_in;
      q_work.first_byte = req_tx_byte;
      unique case (action_type'(req_action))
         ACT_SEND: begin
            q_work.start_tx = 1'b1;
         end
         ACT_NUMBER: begin
            q_work.start_tx   = 1'b1;
            q_work.load_num   = 1'b1;
            q_work.first_byte = CMD_NUMBER;
         end
         ACT_RECV: begin
            q_work.start_rx = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign req_ready = q_ready;
   assign q_push    = req_valid & q_ready;

endmodule
`default_nettype wire

/* hdl/swbt_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swbt_queue
// Small FIFO of work records between front and back.
// ----------------------------------------------------------------------------
module swbt_queue import swbt_pkg::*; #(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_work,
   output logic     push_ready,
   output logic     pop_valid,
   input  logic     pop,
   output work_type pop_work
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   work_type         entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_work   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_work;
      end
   end

endmodule
`default_nettype wire

/* hdl/swbt_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swbt_back
// Line engine: arms, waits for the start edge, times and shifts bits, and
// registers one result item per work record.
// ----------------------------------------------------------------------------
module swbt_back import swbt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] bit_period,
   input  logic [14:0] half_bit_period,
   input  logic        q_valid,
   input  work_type    q_work,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_drive_mode,
   output logic        rsp_drive_level,
   output logic [7:0]  rsp_rx_data,
   output logic        rsp_rx_valid,
   output logic        rsp_tx_done,
   output logic        rsp_busy_res
);

   typedef enum logic [2:0] {
      MODE_IDLE = 3'b001,
      MODE_TX   = 3'b010,
      MODE_RX   = 3'b100
   } mode_type;

   typedef enum logic [4:0] {
      PH_WAIT = 5'b00001,   // armed, waiting for the falling edge
      PH_HALF = 5'b00010,
      PH_PULL = 5'b00100,
      PH_HIGH = 5'b01000,
      PH_DATA = 5'b10000
   } phase_type;

   mode_type    mode_ff, mode_in;
   phase_type   phase_ff, phase_in;
   logic [15:0] tick_ff, tick_in;
   logic [2:0]  bit_ff, bit_in;
   logic [7:0]  shift_ff, shift_in;
   logic [31:0] pending_ff, pending_in;
   logic [2:0]  left_ff, left_in;
   logic        prev_ff, prev_in;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff, rsp_in;

   logic        advance;
   logic [16:0] tick_plus;
   logic [16:0] target;
   logic        hit;
   logic        timing;
   logic [7:0]  rx_shift;

   assign advance = !rsp_valid_ff || rsp_ready;
   assign q_pop   = q_valid && advance;

   // a zero period behaves as one tick
   always_comb begin
      if (phase_ff == PH_HALF) begin
         target = (half_bit_period == '0) ? 17'd1 : {2'b00, half_bit_period};
      end else begin
         target = (bit_period == '0) ? 17'd1 : {1'b0, bit_period};
      end
   end

   assign tick_plus = {1'b0, tick_ff} + 17'd1;
   assign hit       = (tick_plus >= target);
   assign timing    = (mode_ff != MODE_IDLE) && (phase_ff != PH_WAIT);
   assign rx_shift  = {shift_ff[6:0], q_work.line};

   always_comb begin
      mode_in    = mode_ff;
      phase_in   = phase_ff;
      tick_in    = tick_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      pending_in = pending_ff;
      left_in    = left_ff;
      prev_in    = q_work.line;
      rsp_in     = '0;

      if (timing) begin
         tick_in = hit ? 16'd0 : tick_plus[15:0];
      end

      unique case (mode_ff)
         MODE_IDLE: begin
            if (q_work.start_tx) begin
               mode_in  = MODE_TX;
               phase_in = PH_WAIT;
               shift_in = q_work.first_byte;
               left_in  = q_work.load_num ? NUMBER_BYTES : 3'd0;
               if (q_work.load_num) begin
                  pending_in = q_work.number;
               end
            end else if (q_work.start_rx) begin
               mode_in  = MODE_RX;
               phase_in = PH_WAIT;
               shift_in = '0;
            end
         end
         MODE_TX: begin
            unique case (phase_ff)
               PH_WAIT: begin
                  if (prev_ff && !q_work.line) begin
                     phase_in = PH_HALF;
                     tick_in  = '0;
                     bit_in   = '0;
                  end
               end
               PH_HALF: if (hit) phase_in = PH_PULL;
               PH_PULL: if (hit) phase_in = PH_HIGH;
               PH_HIGH: begin
                  if (hit) begin
                     phase_in = PH_DATA;
                     bit_in   = '0;
                  end
               end
               PH_DATA: begin
                  if (hit) begin
                     if (bit_ff == LAST_BIT) begin
                        bit_in = '0;
                        if (left_ff != '0) begin
                           // next byte of the number, re-arm for a new edge
                           shift_in   = pending_ff[31:24];
                           pending_in = {pending_ff[23:0], 8'h00};
                           left_in    = left_ff - 3'd1;
                           phase_in   = PH_WAIT;
                        end else begin
                           mode_in        = MODE_IDLE;
                           phase_in       = PH_WAIT;
                           rsp_in.tx_done = 1'b1;
                        end
                     end else begin
                        bit_in = bit_ff + 3'd1;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         MODE_RX: begin
            unique case (phase_ff)
               PH_WAIT: begin
                  if (prev_ff && !q_work.line) begin
                     phase_in = PH_HALF;
                     tick_in  = '0;
                     bit_in   = '0;
                     shift_in = '0;
                  end
               end
               PH_HALF: if (hit) phase_in = PH_DATA;
               default: begin
                  if (hit) begin
                     shift_in = rx_shift;
                     if (bit_ff == LAST_BIT) begin
                        bit_in          = '0;
                        rsp_in.rx_data  = rx_shift;
                        rsp_in.rx_valid = 1'b1;
                        mode_in         = MODE_IDLE;
                        phase_in        = PH_WAIT;
                     end else begin
                        bit_in = bit_ff + 3'd1;
                     end
                  end
               end
            endcase
         end
         default: begin
         end
      endcase

      if (mode_in == MODE_TX) begin
         unique case (phase_in)
            PH_PULL: rsp_in.drive_mode = DRV_WEAK;
            PH_HIGH: begin
               rsp_in.drive_mode  = DRV_STRONG;
               rsp_in.drive_level = 1'b1;
            end
            PH_DATA: begin
               rsp_in.drive_mode  = DRV_STRONG;
               rsp_in.drive_level = shift_in[~bit_in];
            end
            default: rsp_in.drive_mode = DRV_RELEASED;
         endcase
      end
      rsp_in.busy = (mode_in != MODE_IDLE);
   end

   assign rsp_valid_in = advance ? q_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         phase_ff     <= PH_WAIT;
         tick_ff      <= '0;
         bit_ff       <= '0;
         shift_ff     <= '0;
         pending_ff   <= '0;
         left_ff      <= '0;
         prev_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            mode_ff    <= mode_in;
            phase_ff   <= phase_in;
            tick_ff    <= tick_in;
            bit_ff     <= bit_in;
            shift_ff   <= shift_in;
            pending_ff <= pending_in;
            left_ff    <= left_in;
            prev_ff    <= prev_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive_mode  = rsp_ff.drive_mode;
   assign rsp_drive_level = rsp_ff.drive_level;
   assign rsp_rx_data     = rsp_ff.rx_data;
   assign rsp_rx_valid    = rsp_ff.rx_valid;
   assign rsp_tx_done     = rsp_ff.tx_done;
   assign rsp_busy_res    = rsp_ff.busy;

endmodule
`default_nettype wire

/* hdl/single_wire_byte_transceiver_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Single-wire half-duplex byte transceiver, slave side. Each request item is
// one sample tick of the shared wire, optionally carrying a send, receive or
// send-number request; each produces exactly one result item with the drive
// state of the wire and the rx/tx pulses. One item per clock is sustained
// while the result side accepts: the front decodes into a small FIFO
// (QUEUE_DEPTH entries) and the line engine consumes one record per cycle
// into a registered output stage, after the queue register. The bit timing
// counter and shift logic of the engine form the single per-item step.
// Register 0 (byte address 0) is bit_period, register 1 (address 4) is
// half_bit_period; write them only while the block is idle.
// ----------------------------------------------------------------------------
// single_wire_byte_transceiver_top
// Top level: CSR block, request front end, work queue and line engine.
// ----------------------------------------------------------------------------
module single_wire_byte_transceiver_top import swbt_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_action,
   input  logic [7:0]            req_tx_byte,
   input  logic [31:0]           req_number,
   input  logic                  req_line_in,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_drive_mode,
   output logic                  rsp_drive_level,
   output logic [7:0]            rsp_rx_data,
   output logic                  rsp_rx_valid,
   output logic                  rsp_tx_done,
   output logic                  rsp_busy_res,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [15:0] bit_period_ff;
   logic [14:0] half_bit_period_ff;
   logic        csr_write;

   logic        q_push;
   logic        q_ready;
   work_type    q_push_work;
   logic        q_valid;
   logic        q_pop;
   work_type    q_pop_work;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_period_ff      <= BIT_PERIOD_RST;
         half_bit_period_ff <= HALF_BIT_PERIOD_RST;
      end else if (csr_write) begin
         unique case (reg_index_type'(csr_paddr[2]))
            REG_BIT_PERIOD:      bit_period_ff      <= csr_pwdata[15:0];
            REG_HALF_BIT_PERIOD: half_bit_period_ff <= csr_pwdata[14:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_index_type'(csr_paddr[2]))
         REG_BIT_PERIOD:      csr_prdata = {16'd0, bit_period_ff};
         REG_HALF_BIT_PERIOD: csr_prdata = {17'd0, half_bit_period_ff};
         default:             csr_prdata = '0;
      endcase
   end

   swbt_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_action  (req_action),
      .req_tx_byte (req_tx_byte),
      .req_number  (req_number),
      .req_line_in (req_line_in),
      .q_push      (q_push),
      .q_work      (q_push_work),
      .q_ready     (q_ready)
   );

   swbt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_work  (q_push_work),
      .push_ready (q_ready),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_work   (q_pop_work)
   );

   swbt_back u_back (
      .clock           (clock),
      .reset           (reset),
      .bit_period      (bit_period_ff),
      .half_bit_period (half_bit_period_ff),
      .q_valid         (q_valid),
      .q_work          (q_pop_work),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_drive_mode  (rsp_drive_mode),
      .rsp_drive_level (rsp_drive_level),
      .rsp_rx_data     (rsp_rx_data),
      .rsp_rx_valid    (rsp_rx_valid),
      .rsp_tx_done     (rsp_tx_done),
      .rsp_busy_res    (rsp_busy_res)
   );

   a_pop_needs_item : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("engine popped an empty queue");

   a_result_after_pop : assert property (@(posedge clock) disable iff (reset)
      q_pop |=> rsp_valid)
      else $error("popped item produced no result");

   a_done_ends_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_tx_done || rsp_rx_valid) |-> !rsp_busy_res)
      else $error("completion reported while still busy");

   a_drive_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_drive_mode == DRV_RELEASED) ||
         (rsp_busy_res && (rsp_drive_mode == DRV_WEAK || rsp_drive_mode == DRV_STRONG)))
      else $error("line driven while idle or bad drive code");

endmodule
`default_nettype wire

/* verif/single_wire_byte_transceiver_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_wire_byte_transceiver_top_test
// Self-checking bench for the single-wire byte transceiver. A partner-side
// wire waveform drives send, receive and number transfers through several
// bit timings, including zero and maximum periods. Both handshake sides
// idle and stall at random. Every result item is compared, field by field,
// against an in-bench line model.
// ----------------------------------------------------------------------------
import swbt_pkg::*;

typedef enum logic [1:0] {
   LINK_IDLE = 2'd0,
   LINK_TX   = 2'd1,
   LINK_RX   = 2'd2
} link_mode_type;

// PH_PULLUP is the weak pull-up bit when sending, the sampling phase when receiving
typedef enum logic [3:0] {
   PH_ARMED  = 4'd0,
   PH_HALF   = 4'd1,
   PH_PULLUP = 4'd2,
   PH_HIGH   = 4'd3,
   PH_DATA   = 4'd4
} link_phase_type;

class line_state_scoreboard;
   logic [15:0]    bit_ticks;
   logic [14:0]    half_ticks;
   link_mode_type  mode;
   link_phase_type phase;
   logic [15:0]    tick_count;
   logic [2:0]     bit_index;
   logic [7:0]     shift_reg;
   logic [31:0]    pending_bytes;
   logic [2:0]     bytes_left;
   logic           prev_line;
   result_type     line_states_due[$];
   int             mismatches;

   function new();
      bit_ticks     = BIT_PERIOD_RST;
      half_ticks    = HALF_BIT_PERIOD_RST;
      mode          = LINK_IDLE;
      phase         = PH_ARMED;
      tick_count    = '0;
      bit_index     = '0;
      shift_reg     = '0;
      pending_bytes = '0;
      bytes_left    = '0;
      prev_line     = 1'b1;
      mismatches    = 0;
   endfunction

   function void load_register(reg_index_type idx, logic [31:0] value);
      case (idx)
         REG_BIT_PERIOD: begin
            bit_ticks = value[15:0];
         end
         REG_HALF_BIT_PERIOD: begin
            half_ticks = value[14:0];
         end
         default: begin
         end
      endcase
   endfunction

   // a target of zero hits on every tick, same as one
   function bit timing_point(logic [15:0] target);
      logic [16:0] next_count;
      next_count = {1'b0, tick_count} + 17'd1;
      if (next_count >= {1'b0, target}) begin
         tick_count = '0;
         return 1'b1;
      end
      tick_count = next_count[15:0];
      return 1'b0;
   endfunction

   function void note_tick(action_type act, logic [7:0] txb, logic [31:0] num, logic lvl);
      result_type due;
      due = '0;
      if (mode == LINK_IDLE) begin
         case (act)
            ACT_SEND: begin
               mode       = LINK_TX;
               phase      = PH_ARMED;
               shift_reg  = txb;
               bytes_left = '0;
            end
            ACT_NUMBER: begin
               mode          = LINK_TX;
               phase         = PH_ARMED;
               shift_reg     = CMD_NUMBER;
               pending_bytes = num;
               bytes_left    = NUMBER_BYTES;
            end
            ACT_RECV: begin
               mode      = LINK_RX;
               phase     = PH_ARMED;
               shift_reg = '0;
            end
            default: begin
            end
         endcase
      end else if (phase == PH_ARMED) begin
         if (prev_line && !lvl) begin
            phase      = PH_HALF;
            tick_count = '0;
            bit_index  = '0;
            if (mode == LINK_RX) begin
               shift_reg = '0;
            end
         end
      end else if (mode == LINK_TX) begin
         case (phase)
            PH_HALF: begin
               if (timing_point({1'b0, half_ticks})) begin
                  phase = PH_PULLUP;
               end
            end
            PH_PULLUP: begin
               if (timing_point(bit_ticks)) begin
                  phase = PH_HIGH;
               end
            end
            PH_HIGH: begin
               if (timing_point(bit_ticks)) begin
                  phase     = PH_DATA;
                  bit_index = '0;
               end
            end
            default: begin
               if (timing_point(bit_ticks)) begin
                  if (bit_index == LAST_BIT) begin
                     bit_index = '0;
                     // number send: next byte waits for a fresh start edge
                     if (bytes_left != '0) begin
                        shift_reg     = pending_bytes[31:24];
                        pending_bytes = {pending_bytes[23:0], 8'h00};
                        bytes_left    = bytes_left - 3'd1;
                        phase         = PH_ARMED;
                     end else begin
                        mode        = LINK_IDLE;
                        phase       = PH_ARMED;
                        due.tx_done = 1'b1;
                     end
                  end else begin
                     bit_index = bit_index + 3'd1;
                  end
               end
            end
         endcase
      end else begin
         if (phase == PH_HALF) begin
            if (timing_point({1'b0, half_ticks})) begin
               phase = PH_PULLUP;
            end
         end else if (timing_point(bit_ticks)) begin
            shift_reg = {shift_reg[6:0], lvl};
            if (bit_index == LAST_BIT) begin
               bit_index    = '0;
               due.rx_data  = shift_reg;
               due.rx_valid = 1'b1;
               mode         = LINK_IDLE;
               phase        = PH_ARMED;
            end else begin
               bit_index = bit_index + 3'd1;
            end
         end
      end
      prev_line = lvl;

      if (mode == LINK_TX) begin
         case (phase)
            PH_PULLUP: begin
               due.drive_mode = DRV_WEAK;
            end
            PH_HIGH: begin
               due.drive_mode  = DRV_STRONG;
               due.drive_level = 1'b1;
            end
            PH_DATA: begin
               due.drive_mode  = DRV_STRONG;
               due.drive_level = shift_reg[LAST_BIT - bit_index];
            end
            default: begin
            end
         endcase
      end
      due.busy = (mode != LINK_IDLE);
      line_states_due.push_back(due);
   endfunction

   function void check_line_state(result_type got);
      result_type due;
      if (line_states_due.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t: result item with none expected", $realtime);
         end
         return;
      end
      due = line_states_due.pop_front();
      if (got !== due) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t: expected %0d/%0d %02h/%0d %0d %0d, got %0d/%0d %02h/%0d %0d %0d",
                     $realtime, due.drive_mode, due.drive_level, due.rx_data, due.rx_valid,
                     due.tx_done, due.busy, got.drive_mode, got.drive_level, got.rx_data,
                     got.rx_valid, got.tx_done, got.busy);
         end
      end
   endfunction
endclass

module single_wire_byte_transceiver_top_test;

   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_CYCLES = 150;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_action  = ACT_TICK;
   logic [7:0]            req_tx_byte = '0;
   logic [31:0]           req_number  = '0;
   logic                  req_line_in = 1'b1;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   logic [1:0]            rsp_drive_mode;
   logic                  rsp_drive_level;
   logic [7:0]            rsp_rx_data;
   logic                  rsp_rx_valid;
   logic                  rsp_tx_done;
   logic                  rsp_busy_res;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   line_state_scoreboard sb;
   result_type           rsp_seen;
   int                   items_sent    = 0;
   int                   sender_idle_pct = 0;
   int                   stall_pct     = 0;
   int                   hold_requests = 0;
   int                   hold_served   = 0;
   int                   hold_left     = 0;
   int                   quiet_cycles  = 0;
   logic                 partner_level = 1'b1;
   int                   partner_run   = 0;

   single_wire_byte_transceiver_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_tx_byte     (req_tx_byte),
      .req_number      (req_number),
      .req_line_in     (req_line_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_drive_mode  (rsp_drive_mode),
      .rsp_drive_level (rsp_drive_level),
      .rsp_rx_data     (rsp_rx_data),
      .rsp_rx_valid    (rsp_rx_valid),
      .rsp_tx_done     (rsp_tx_done),
      .rsp_busy_res    (rsp_busy_res),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always #2 clock = ~clock;

   // result side: check, then pick next ready (long hold-offs counted here)
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_seen.drive_mode  = rsp_drive_mode;
         rsp_seen.drive_level = rsp_drive_level;
         rsp_seen.rx_data     = rsp_rx_data;
         rsp_seen.rx_valid    = rsp_rx_valid;
         rsp_seen.tx_done     = rsp_tx_done;
         rsp_seen.busy        = rsp_busy_res;
         sb.check_line_state(rsp_seen);
      end
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("single_wire_byte_transceiver_top_test failed");
            $finish;
         end
      end
   end

   function automatic int bit_span();
      int b;
      b = sb.bit_ticks;
      return (b == 0) ? 1 : ((b > 64) ? 64 : b);
   endfunction

   function automatic int half_span();
      int h;
      h = sb.half_ticks;
      return (h == 0) ? 1 : ((h > 64) ? 64 : h);
   endfunction

   // partner waveform: runs of one tick up to 2 bit times, so falling edges keep coming
   function automatic logic partner_line();
      if (partner_run == 0) begin
         partner_level = ~partner_level;
         partner_run   = $urandom_range(2 * bit_span(), 1);
      end
      partner_run--;
      return partner_level;
   endfunction

   task automatic offer_item(action_type act, logic [7:0] txb, logic [31:0] num, logic lvl);
      int gap;
      gap = 0;
      while ($urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= act;
      req_tx_byte <= txb;
      req_number  <= num;
      req_line_in <= lvl;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_tick(act, txb, num, lvl);
      items_sent++;
   endtask

   // long number sends only at short bit times
   task automatic offer_partner_tick();
      action_type act;
      if ($urandom_range(19) == 0) begin
         act = action_type'($urandom_range(3));
         if (act == ACT_NUMBER && sb.bit_ticks > 16'd8) act = ACT_SEND;
         offer_item(act, 8'($urandom), 32'($urandom), partner_line());
      end else begin
         offer_item(ACT_TICK, 8'($urandom), 32'($urandom), partner_line());
      end
   endtask

   task automatic offer_noise(int count);
      repeat (count) begin
         offer_item(action_type'($urandom_range(3)), 8'($urandom), 32'($urandom),
                    1'($urandom_range(1)));
      end
   endtask

   task automatic finish_transfer();
      while (sb.mode != LINK_IDLE) offer_partner_tick();
   endtask

   task automatic run_session();
      int         pick;
      int         span;
      action_type act;
      finish_transfer();
      pick = $urandom_range(99);
      if (pick < 10) begin
         offer_noise($urandom_range(20, 8));
      end else begin
         if (pick < 45) act = ACT_SEND;
         else if (pick >= 80 && sb.bit_ticks <= 16'd8) act = ACT_NUMBER;
         else act = ACT_RECV;
         partner_level = 1'b1;
         partner_run   = $urandom_range(4, 1);
         offer_item(act, 8'($urandom), 32'($urandom), 1'b1);
         span = ((act == ACT_NUMBER) ? 5 : 1) * (half_span() + 11 * bit_span() + 4);
         repeat (span) offer_partner_tick();
      end
   endtask

   task automatic run_sessions(int count);
      int stop;
      stop = items_sent + count;
      while (items_sent < stop) run_session();
   endtask

   task automatic wait_for_line_states();
      req_valid <= 1'b0;
      while (sb.line_states_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.load_register(idx, value);
   endtask

   task automatic set_periods(logic [31:0] bit_word, logic [31:0] half_word);
      finish_transfer();
      wait_for_line_states();
      write_reg(REG_BIT_PERIOD, bit_word);
      write_reg(REG_HALF_BIT_PERIOD, half_word);
   endtask

   initial begin
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset timing, no idling
      run_sessions(150);

      // upper bits masked off, leaving zero periods (act as one tick)
      set_periods(32'hFFFF_0000, 32'hFFFF_8000);
      offer_item(ACT_TICK, 8'h00, 32'h0000_0000, 1'b0);
      offer_item(ACT_TICK, 8'hFF, 32'hFFFF_FFFF, 1'b1);
      offer_item(ACT_SEND, 8'hFF, 32'h0000_0000, 1'b1);
      offer_item(ACT_NUMBER, 8'h00, 32'h8000_0000, 1'b1);  // ignored while busy
      offer_item(ACT_TICK, 8'h00, 32'h0000_0000, 1'b0);    // start edge
      repeat (11) offer_item(ACT_TICK, 8'h00, 32'h0000_0000, 1'b0);
      offer_item(ACT_RECV, 8'h00, 32'h0000_0000, 1'b1);
      offer_item(ACT_TICK, 8'h00, 32'h0000_0000, 1'b0);
      for (int i = 0; i < 9; i++) begin
         offer_item(ACT_TICK, 8'h00, 32'h0000_0000, i[0]);
      end
      offer_item(ACT_NUMBER, 8'h00, 32'h7FFF_FFFF, 1'b1);
      run_sessions(60);

      set_periods(32'd3, 32'd1);
      sender_idle_pct = 74;
      run_sessions(250);

      set_periods(32'd2, 32'd1);
      sender_idle_pct = 0;
      stall_pct       = 74;
      hold_requests++;
      run_sessions(250);

      set_periods(32'd5, 32'd2);
      sender_idle_pct = 15;
      stall_pct       = 15;
      run_sessions(120);
      wait_for_line_states();
      run_sessions(130);

      set_periods(32'd4, 32'd3);
      sender_idle_pct = 0;
      stall_pct       = 0;
      run_sessions(200);

      // widest periods: arm and start only, no transfer can finish
      set_periods(32'd65535, 32'd32767);
      offer_noise(20);

      wait_for_line_states();
      if (sb.mismatches == 0 && sb.line_states_due.size() == 0) begin
         $display("single_wire_byte_transceiver_top_test passed");
      end else begin
         $display("single_wire_byte_transceiver_top_test failed");
      end
      $finish;
   end

endmodule
